FILE: rtl/core/ddfd_pkg.sv
// ----------------------------------------------------------------------------
// ddfd_pkg
// Shared types and constants of the deadline dual-FIFO dispatcher.
// ----------------------------------------------------------------------------
package ddfd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int TAG_W     = 16;
  localparam int EXPIRE_W  = 30;
  localparam int LIMIT_W   = 16;
  localparam int BATCH_W   = 17;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [EXPIRE_W-1:0] SYNC_EXPIRE_RST  = EXPIRE_W'(50);
  localparam logic [EXPIRE_W-1:0] ASYNC_EXPIRE_RST = EXPIRE_W'(500);
  localparam logic [LIMIT_W-1:0]  BATCH_LIMIT_RST  = LIMIT_W'(2);

  // Register indexes (word address).
  localparam logic [1:0] REG_SYNC_EXPIRE  = 2'd0;
  localparam logic [1:0] REG_ASYNC_EXPIRE = 2'd1;
  localparam logic [1:0] REG_BATCH_LIMIT  = 2'd2;

  // Queue class index: matches the is_sync bit.
  localparam logic CLS_ASYNC = 1'b0;
  localparam logic CLS_SYNC  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_e;

  typedef struct packed {
    op_e              op;
    logic [TAG_W-1:0] tag;
    logic             is_sync;
  } cmd_t;

  typedef struct packed {
    logic [EXPIRE_W-1:0] sync_ttl;
    logic [EXPIRE_W-1:0] async_ttl;
    logic [LIMIT_W-1:0]  batch_limit;
  } cfg_t;

endpackage

FILE: rtl/core/deadline_dual_fifo_dispatcher_top.sv
// ----------------------------------------------------------------------------
// deadline_dual_fifo_dispatcher_top
// Deadline scheduler over a sync and an async request FIFO.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  -----------------------------------
//  command   start / busy               operation_i, request_tag_i, is_sync_i
//  result    done_o (one-cycle strobe)  status_o, out_tag_o, out_is_sync_o,
//                                       out_was_expired_o, queues_empty_o
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Flow: a beat enters a two-entry command queue. The execution side runs
// add, tick and unused codes from its idle state; a dispatch waits in the
// exec state for the registered read of both FIFO heads from their RAMs.
// Add/tick beats sustain one per cycle unless a dispatch holds the back.
// The result strobe is registered, rising in the cycle after execution.
// Reset: async, active low; clears pointers, counts, time and batch counters.
// FIFO storage is not cleared: only slots holding live entries are read.
// Stalls: busy rises only while the command queue is full; the receiver
// cannot hold results off, so nothing else stalls.
//
module deadline_dual_fifo_dispatcher_top import ddfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command beat
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [TAG_W-1:0]  request_tag_i,
  input  logic              is_sync_i,
  // result beat
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [TAG_W-1:0]  out_tag_o,
  output logic              out_is_sync_o,
  output logic              out_was_expired_o,
  output logic              queues_empty_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;

  // Register file: write in the access phase, word index from paddr.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_ttl    <= SYNC_EXPIRE_RST;
      cfg_q.async_ttl   <= ASYNC_EXPIRE_RST;
      cfg_q.batch_limit <= BATCH_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SYNC_EXPIRE:  cfg_q.sync_ttl    <= pwdata[EXPIRE_W-1:0];
        REG_ASYNC_EXPIRE: cfg_q.async_ttl   <= pwdata[EXPIRE_W-1:0];
        REG_BATCH_LIMIT:  cfg_q.batch_limit <= pwdata[LIMIT_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_EXPIRE:  prdata = DATA_W'(cfg_q.sync_ttl);
      REG_ASYNC_EXPIRE: prdata = DATA_W'(cfg_q.async_ttl);
      REG_BATCH_LIMIT:  prdata = DATA_W'(cfg_q.batch_limit);
      default:          prdata = '0;
    endcase
  end

  // Front: decode and queue command beats.
  ddfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .operation_i  (operation_i),
    .request_tag_i(request_tag_i),
    .is_sync_i    (is_sync_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back: run commands against the two FIFOs and emit one result each.
  ddfd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .cfg_i            (cfg_q),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_tag_o        (out_tag_o),
    .out_is_sync_o    (out_is_sync_o),
    .out_was_expired_o(out_was_expired_o),
    .queues_empty_o   (queues_empty_o)
  );

endmodule

FILE: rtl/core/ddfd_ram.sv
// ----------------------------------------------------------------------------
// ddfd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ddfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ddfd_front.sv
// ----------------------------------------------------------------------------
// ddfd_front
// Command intake: decode the operation and hold beats in a short queue.
// ----------------------------------------------------------------------------
module ddfd_front import ddfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       operation_i,
  input  logic [TAG_W-1:0] request_tag_i,
  input  logic             is_sync_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  localparam int QW = $clog2(CMDQ_DEPTH);
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q_q [CMDQ_DEPTH];
  logic [QW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  cmd_t            cmd_in;
  logic            push;

  always_comb begin
    cmd_in.tag     = request_tag_i;
    cmd_in.is_sync = is_sync_i;
    case (operation_i)
      OP_ADD:      cmd_in.op = OP_ADD;
      OP_DISPATCH: cmd_in.op = OP_DISPATCH;
      OP_TICK:     cmd_in.op = OP_TICK;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == NW'(CMDQ_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == QW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/ddfd_back.sv
// ----------------------------------------------------------------------------
// ddfd_back
// Execution side: both request FIFOs, time and batch counters, result regs.
// ----------------------------------------------------------------------------
module ddfd_back import ddfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  cfg_t             cfg_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [TAG_W-1:0] out_tag_o,
  output logic             out_is_sync_o,
  output logic             out_was_expired_o,
  output logic             queues_empty_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TAG_W + TIME_BITS;
  localparam int XW = (TIME_BITS > EXPIRE_W) ? TIME_BITS : EXPIRE_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [BATCH_W-1:0] BATCH_MAX = '1;

  bk_state_e state_q, state_d;

  logic [AW-1:0]        head_q [2];
  logic [AW-1:0]        head_d [2];
  logic [CW-1:0]        cnt_q  [2];
  logic [CW-1:0]        cnt_d  [2];
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [BATCH_W-1:0]   batch_q, batch_d;

  logic                 we     [2];
  logic [EW-1:0]        rdata  [2];
  logic [TIME_BITS-1:0] slack  [2];
  logic                 expired[2];
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [AW:0]          wsum;
  logic [XW-1:0]        dl_sum;
  logic [EXPIRE_W-1:0]  expire;
  logic                 cls;

  logic               check, any, pick;
  logic [BATCH_W-1:0] batch_base;

  logic               res_valid;
  status_e            res_status;
  logic [TAG_W-1:0]   res_tag;
  logic               res_sync, res_exp, res_empty;

  logic               done_q;
  status_e            status_q;
  logic [TAG_W-1:0]   tag_q;
  logic               sync_q, exp_q, empty_q;

  for (genvar c = 0; c < 2; c++) begin : g_fifo
    ddfd_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[c]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(head_q[c]),
      .rdata_o(rdata[c])
    );
    // Head has expired when deadline minus now is negative.
    assign slack[c]   = rdata[c][EW-1:TAG_W] - time_q;
    assign expired[c] = (cnt_q[c] != '0) && slack[c][TIME_BITS-1];
  end

  // Tail slot and deadline of an add.
  assign cls    = cmd_i.is_sync;
  assign expire = cls ? cfg_i.sync_ttl : cfg_i.async_ttl;
  assign dl_sum = XW'(time_q) + XW'(expire);
  assign wsum   = (AW + 1)'(head_q[cls]) + (AW + 1)'(cnt_q[cls]);
  assign waddr  = (wsum >= DEPTH_W) ? AW'(wsum - DEPTH_W) : wsum[AW-1:0];
  assign wdata  = {dl_sum[TIME_BITS-1:0], cmd_i.tag};

  // Dispatch choice.
  assign check      = (batch_q > BATCH_W'(cfg_i.batch_limit));
  assign batch_base = check ? '0 : batch_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    batch_d    = batch_q;
    we[0]      = 1'b0;
    we[1]      = 1'b0;
    cmd_pop_o  = 1'b0;
    res_valid  = 1'b0;
    res_status = ST_DONE;
    res_tag    = '0;
    res_sync   = 1'b0;
    res_exp    = 1'b0;
    any        = 1'b0;
    pick       = CLS_SYNC;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_DISPATCH: begin
              // wait in BK_EXEC for the registered head entries
              state_d = BK_EXEC;
            end
            OP_ADD: begin
              cmd_pop_o = 1'b1;
              res_valid = 1'b1;
              if (cnt_q[cls] == FULL_CNT) begin
                res_status = ST_FULL;
              end else begin
                we[cls]    = 1'b1;
                cnt_d[cls] = cnt_q[cls] + 1'b1;
              end
            end
            OP_TICK: begin
              cmd_pop_o = 1'b1;
              res_valid = 1'b1;
              time_d    = time_q + 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
              res_valid = 1'b1;
            end
          endcase
        end
      end
      BK_EXEC: begin
        cmd_pop_o = 1'b1;
        res_valid = 1'b1;
        state_d   = BK_IDLE;
        batch_d   = batch_base;
        if (check && expired[CLS_ASYNC]) begin
          pick    = CLS_ASYNC;
          any     = 1'b1;
          res_exp = 1'b1;
        end else if (check && expired[CLS_SYNC]) begin
          pick    = CLS_SYNC;
          any     = 1'b1;
          res_exp = 1'b1;
        end else if (cnt_q[CLS_SYNC] != '0) begin
          pick = CLS_SYNC;
          any  = 1'b1;
        end else if (cnt_q[CLS_ASYNC] != '0) begin
          pick = CLS_ASYNC;
          any  = 1'b1;
        end
        if (any) begin
          res_status   = ST_DISPATCHED;
          res_tag      = rdata[pick][TAG_W-1:0];
          res_sync     = pick;
          head_d[pick] = (head_q[pick] == LAST_IDX) ? '0 : head_q[pick] + 1'b1;
          cnt_d[pick]  = cnt_q[pick] - 1'b1;
          if (batch_base != BATCH_MAX) begin
            batch_d = batch_base + 1'b1;
          end
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    res_empty = (cnt_d[0] == '0) && (cnt_d[1] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      for (int c = 0; c < 2; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      time_q  <= '0;
      batch_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      time_q  <= time_d;
      batch_q <= batch_d;
      done_q  <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_q <= res_status;
      tag_q    <= res_tag;
      sync_q   <= res_sync;
      exp_q    <= res_exp;
      empty_q  <= res_empty;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign out_tag_o         = tag_q;
  assign out_is_sync_o     = sync_q;
  assign out_was_expired_o = exp_q;
  assign queues_empty_o    = empty_q;

endmodule

FILE: rtl/core/ddfd_checker.sv
// ----------------------------------------------------------------------------
// ddfd_checker
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module ddfd_checker import ddfd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic [TAG_W-1:0] out_tag_o,
  input logic             out_is_sync_o,
  input logic             out_was_expired_o,
  input logic             queues_empty_o,
  input logic             pready
);

  // Only a dispatched beat carries a tag and class.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_DISPATCHED) |->
      (out_tag_o == '0) && !out_is_sync_o && !out_was_expired_o)
    else $error("non-dispatch result carries request fields");

  // Expiry pick implies a dispatch.
  a_exp_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_was_expired_o |-> (status_o == ST_DISPATCHED))
    else $error("expired flag without dispatch");

  // Nothing to dispatch means both queues are empty.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> queues_empty_o)
    else $error("empty status with non-empty queues");

  // A result right after an all-empty result cannot be a dispatch.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && queues_empty_o ##1 done_o |-> (status_o != ST_DISPATCHED))
    else $error("dispatch from empty queues");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind deadline_dual_fifo_dispatcher_top ddfd_checker u_ddfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .done_o           (done_o),
  .status_o         (status_o),
  .out_tag_o        (out_tag_o),
  .out_is_sync_o    (out_is_sync_o),
  .out_was_expired_o(out_was_expired_o),
  .queues_empty_o   (queues_empty_o),
  .pready           (pready)
);

FILE: bench/tb_deadline_dual_fifo_dispatcher_top.sv
// ----------------------------------------------------------------------------
// tb_deadline_dual_fifo_dispatcher_top
// Self-checking bench for the deadline dual-FIFO dispatcher. Command beats go
// in over start/busy. Every result strobe is compared field by field against
// an in-bench scheduler model. The expire times and the batch limit are
// reprogrammed over APB between traffic phases and read back.
// ----------------------------------------------------------------------------
module tb_deadline_dual_fifo_dispatcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ddfd_pkg::*;

  localparam int QD          = QUEUE_DEPTH_DEF;
  localparam int TW          = TIME_BITS_DEF;
  localparam int PHASE_BEATS = 236;
  // Longest honest quiet stretch: the longest sender gap plus the queue and
  // dispatch latency, or one reprogramming pass.
  localparam int STALL_LIMIT = 1000;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [EXPIRE_W-1:0] EXPIRE_MAX = '1;
  localparam logic [LIMIT_W-1:0]  LIMIT_MAX  = '1;

  // Pacing of the sender and traffic mixes of the random part.
  typedef enum logic [1:0] {PACE_BURST, PACE_UNIFORM, PACE_SPARSE} pace_e;
  typedef enum logic [1:0] {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_TICKS} mix_e;

  typedef struct packed {
    status_e          status;
    logic [TAG_W-1:0] tag;
    logic             is_sync;
    logic             expired;
    logic             empty;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        operation_i;
  logic [TAG_W-1:0]  request_tag_i;
  logic              is_sync_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [TAG_W-1:0]  out_tag_o;
  logic              out_is_sync_o;
  logic              out_was_expired_o;
  logic              queues_empty_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Scheduler model: both FIFOs indexed by class, time and batch counters,
  // and the programmed limits.
  logic [TAG_W-1:0]    mdl_tag      [2][QD];
  logic [TW-1:0]       mdl_deadline [2][QD];
  int unsigned         mdl_head     [2];
  int unsigned         mdl_count    [2];
  logic [BATCH_W-1:0]  mdl_batch;
  logic [TW-1:0]       mdl_now;
  logic [EXPIRE_W-1:0] lim_sync_ttl;
  logic [EXPIRE_W-1:0] lim_async_ttl;
  logic [LIMIT_W-1:0]  lim_batch;

  outcome_t    expected_results[$];
  pace_e       pace;
  int unsigned fails;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned phases_run;
  int unsigned served_total;
  int unsigned served_expired;
  int unsigned empty_dispatches;
  int unsigned adds_rejected;
  int unsigned stall_cycles = 0;

  deadline_dual_fifo_dispatcher_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .request_tag_i     (request_tag_i),
    .is_sync_i         (is_sync_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .out_tag_o         (out_tag_o),
    .out_is_sync_o     (out_is_sync_o),
    .out_was_expired_o (out_was_expired_o),
    .queues_empty_o    (queues_empty_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk_i = ~clk_i;

  // A head is overdue when its deadline minus the current time is negative
  // in two's complement, so the compare survives counter wrap.
  function automatic logic head_overdue(logic cls);
    logic [TW-1:0] slack;
    if (mdl_count[cls] == 0) return 1'b0;
    slack = mdl_deadline[cls][mdl_head[cls]] - mdl_now;
    return slack[TW-1];
  endfunction

  // Advance the model by one command and return the result it causes.
  function automatic outcome_t schedule_step(op_e op, logic [TAG_W-1:0] tag, logic cls);
    outcome_t    res;
    logic        picked;
    logic        pick;
    int unsigned slot;
    res    = '{status: ST_DONE, tag: '0, is_sync: 1'b0, expired: 1'b0, empty: 1'b0};
    picked = 1'b0;
    pick   = CLS_ASYNC;
    case (op)
      OP_ADD: begin
        if (mdl_count[cls] >= QD) begin
          res.status = ST_FULL;
        end else begin
          slot = (mdl_head[cls] + mdl_count[cls]) % QD;
          mdl_tag[cls][slot]      = tag;
          mdl_deadline[cls][slot] = mdl_now +
              TW'((cls == CLS_SYNC) ? lim_sync_ttl : lim_async_ttl);
          mdl_count[cls]++;
        end
      end
      OP_DISPATCH: begin
        // Batch exhausted: clear it and let an overdue head jump the line,
        // async first.
        if (mdl_batch > BATCH_W'(lim_batch)) begin
          mdl_batch = '0;
          if (head_overdue(CLS_ASYNC)) begin
            picked = 1'b1;
            pick   = CLS_ASYNC;
          end else if (head_overdue(CLS_SYNC)) begin
            picked = 1'b1;
            pick   = CLS_SYNC;
          end
          res.expired = picked;
        end
        if (!picked) begin
          if (mdl_count[CLS_SYNC] != 0) begin
            picked = 1'b1;
            pick   = CLS_SYNC;
          end else if (mdl_count[CLS_ASYNC] != 0) begin
            picked = 1'b1;
            pick   = CLS_ASYNC;
          end
        end
        if (picked) begin
          res.status  = ST_DISPATCHED;
          res.is_sync = pick;
          res.tag     = mdl_tag[pick][mdl_head[pick]];
          mdl_head[pick] = (mdl_head[pick] + 1) % QD;
          mdl_count[pick]--;
          if (mdl_batch != '1) mdl_batch++;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      OP_TICK: mdl_now++;
      default: ;
    endcase
    res.empty = (mdl_count[CLS_SYNC] == 0) && (mdl_count[CLS_ASYNC] == 0);
    return res;
  endfunction

  // Send one command beat after a pacing gap and record what it must return.
  // Keep start high across back-to-back beats; drop it only for a real gap.
  task automatic send_beat(op_e op, logic [TAG_W-1:0] tag, logic cls);
    int unsigned gap;
    case (pace)
      PACE_BURST:   gap = 0;
      PACE_UNIFORM: gap = $urandom_range(0, 13);
      default:      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : 0;
    endcase
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    operation_i   <= op;
    request_tag_i <= tag;
    is_sync_i     <= cls;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_results.push_back(schedule_step(op, tag, cls));
    beats_sent++;
  endtask

  // Hold off the sender until every outstanding result has been checked.
  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram all limits while the block is idle, with junk above each
  // register's width, poke the unmapped slot, then read every register back.
  task automatic program_limits(logic [EXPIRE_W-1:0] sync_exp,
                                logic [EXPIRE_W-1:0] async_exp,
                                logic [LIMIT_W-1:0]  limit);
    logic [DATA_W-1:0] want [3];
    logic [DATA_W-1:0] mask [3];
    logic [DATA_W-1:0] rd;
    wait_results_drained();
    want[REG_SYNC_EXPIRE]  = DATA_W'(sync_exp);
    want[REG_ASYNC_EXPIRE] = DATA_W'(async_exp);
    want[REG_BATCH_LIMIT]  = DATA_W'(limit);
    mask[REG_SYNC_EXPIRE]  = DATA_W'(EXPIRE_MAX);
    mask[REG_ASYNC_EXPIRE] = DATA_W'(EXPIRE_MAX);
    mask[REG_BATCH_LIMIT]  = DATA_W'(LIMIT_MAX);
    for (int i = 0; i < 3; i++)
      apb_access(1'b1, 2'(i), want[i] | ($urandom() & ~mask[i]), rd);
    apb_access(1'b1, REG_UNMAPPED, $urandom(), rd);
    lim_sync_ttl  = sync_exp;
    lim_async_ttl = async_exp;
    lim_batch     = limit;
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, 2'(i), '0, rd);
      if (rd !== want[i]) begin
        $error("register %0d readback: expected %0h, got %0h", i, want[i], rd);
        fails++;
      end
    end
  endtask

  // Empty dispatch, the unused code with all payload bits set, and a tick.
  task automatic test_idle_commands();
    send_beat(OP_DISPATCH, '1, CLS_SYNC);
    send_beat(OP_NOP, '1, CLS_SYNC);
    send_beat(OP_TICK, '0, CLS_ASYNC);
  endtask

  // Under the reset limits the sync head goes before an older async head.
  task automatic test_class_order();
    send_beat(OP_ADD, '1, CLS_ASYNC);
    send_beat(OP_ADD, '0, CLS_SYNC);
    send_beat(OP_DISPATCH, '0, CLS_ASYNC);
    send_beat(OP_DISPATCH, '0, CLS_ASYNC);
  endtask

  // Fill the async FIFO with zero expire times; the extra add is rejected.
  task automatic test_fifo_full();
    program_limits('0, '0, '0);
    repeat (QD + 1) send_beat(OP_ADD, TAG_W'($urandom()), CLS_ASYNC);
  endtask

  // One tick makes the async heads overdue; with a zero batch limit they
  // beat a fresh sync head whose slack is exactly zero.
  task automatic test_expiry_priority();
    send_beat(OP_TICK, '0, CLS_SYNC);
    send_beat(OP_ADD, TAG_W'($urandom()), CLS_SYNC);
    repeat (3) send_beat(OP_DISPATCH, '1, CLS_SYNC);
  endtask

  // Random traffic under one limit setting. Mixes change every 32 beats so
  // the FIFOs swing between empty and full; pacing changes every 40.
  task automatic test_random_traffic(logic [EXPIRE_W-1:0] sync_exp,
                                     logic [EXPIRE_W-1:0] async_exp,
                                     logic [LIMIT_W-1:0]  limit);
    int unsigned counted;
    int unsigned k;
    int unsigned roll;
    int unsigned add_pct;
    int unsigned disp_pct;
    mix_e        mix;
    op_e         op;
    program_limits(sync_exp, async_exp, limit);
    phases_run++;
    counted  = 0;
    k        = 0;
    mix      = MIX_BALANCED;
    add_pct  = 40;
    disp_pct = 35;
    while (counted < PHASE_BEATS) begin
      if (k % 32 == 0) begin
        mix = mix_e'($urandom_range(0, 3));
        case (mix)
          MIX_FILL:  begin add_pct = 70; disp_pct = 13; end
          MIX_DRAIN: begin add_pct = 13; disp_pct = 70; end
          MIX_TICKS: begin add_pct = 18; disp_pct = 18; end
          default:   begin add_pct = 40; disp_pct = 35; end
        endcase
      end
      if (k % 40 == 0) pace = pace_e'($urandom_range(0, 2));
      // Pause the sender once per phase until the result side is empty.
      if (k == PHASE_BEATS / 2) wait_results_drained();
      roll = $urandom_range(0, 99);
      if (roll >= 96)                      op = OP_NOP;
      else if (roll < add_pct)             op = OP_ADD;
      else if (roll < add_pct + disp_pct)  op = OP_DISPATCH;
      else                                 op = OP_TICK;
      send_beat(op, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
      if (op != OP_NOP) counted++;
      k++;
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no command outstanding");
        fails++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.status == ST_DISPATCHED) served_total++;
        if (want.expired) served_expired++;
        if (want.status == ST_EMPTY) empty_dispatches++;
        if (want.status == ST_FULL) adds_rejected++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
        if (out_tag_o !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, out_tag_o);
          fails++;
        end
        if (out_is_sync_o !== want.is_sync) begin
          $error("out_is_sync: expected %0d, got %0d", want.is_sync, out_is_sync_o);
          fails++;
        end
        if (out_was_expired_o !== want.expired) begin
          $error("out_was_expired: expected %0d, got %0d", want.expired, out_was_expired_o);
          fails++;
        end
        if (queues_empty_o !== want.empty) begin
          $error("queues_empty: expected %0d, got %0d", want.empty, queues_empty_o);
          fails++;
        end
      end
    end
  end

  // Count cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start && busy === 1'b0) || done_o === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout after %0d quiet cycles", stall_cycles);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    operation_i   <= OP_NOP;
    request_tag_i <= '0;
    is_sync_i     <= CLS_ASYNC;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    fails            = 0;
    beats_sent       = 0;
    results_checked  = 0;
    phases_run       = 0;
    served_total     = 0;
    served_expired   = 0;
    empty_dispatches = 0;
    adds_rejected    = 0;
    pace             = PACE_UNIFORM;
    // Model starts from the reset state; FIFO slots stay unwritten.
    mdl_head         = '{0, 0};
    mdl_count        = '{0, 0};
    mdl_batch        = '0;
    mdl_now          = '0;
    lim_sync_ttl     = SYNC_EXPIRE_RST;
    lim_async_ttl    = ASYNC_EXPIRE_RST;
    lim_batch        = BATCH_LIMIT_RST;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_commands();
    test_class_order();
    test_fifo_full();
    test_expiry_priority();

    test_random_traffic(SYNC_EXPIRE_RST, ASYNC_EXPIRE_RST, BATCH_LIMIT_RST);
    test_random_traffic('0, '0, '0);
    test_random_traffic(EXPIRE_MAX, EXPIRE_MAX, LIMIT_MAX);
    test_random_traffic(EXPIRE_W'($urandom_range(0, 20)), EXPIRE_W'($urandom_range(0, 40)),
                        LIMIT_W'($urandom_range(0, 5)));
    test_random_traffic(EXPIRE_MAX, '0, LIMIT_W'(1));
    test_random_traffic(EXPIRE_W'($urandom()), EXPIRE_W'($urandom()), LIMIT_W'($urandom()));

    // Drain the result side, then let the pipeline settle.
    wait_results_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d command beats over %0d random phases; checked %0d results.",
             beats_sent, phases_run, results_checked);
    $display("Dispatched %0d (%0d by expiry), %0d empty dispatches, %0d adds rejected full.",
             served_total, served_expired, empty_dispatches, adds_rejected);
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
